FILE: design/osat_pkg.sv
package osat_pkg;

  localparam logic [1:0] OP_ARM    = 2'd0;
  localparam logic [1:0] OP_DISARM = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam int ID_W  = 4;
  localparam int CNT_W = 32;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [ID_W-1:0]  alarm_id;
    logic [CNT_W-1:0] timeout;
    logic             notify;
  } item_t;

  typedef struct packed {
    logic [ID_W-1:0] fired_id;
    logic            fired_valid;
    logic            last;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic arm;
    logic disarm;
    logic rd_en;
    logic rd_last;
    logic finish;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic walk_done;
  } status_t;

endpackage

FILE: design/osat_ctrl.sv
module osat_ctrl #(
  parameter int ALARM_COUNT = 16,
  parameter int IDX_W = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  osat_pkg::item_t     item,
  input  osat_pkg::status_t   status,
  output logic                busy,
  output osat_pkg::cmd_t      cmd,
  output logic [IDX_W-1:0]    rd_addr
);
  import osat_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    WALK,
    DRAIN,
    FINISH
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ALARM_COUNT - 1);

  state_t           state;
  logic [IDX_W-1:0] idx;
  logic             take;
  logic             id_ok;

  assign take  = start && (state == IDLE);
  assign id_ok = (32'(item.alarm_id) < 32'(ALARM_COUNT));
  assign busy  = (state != IDLE);

  always_comb begin
    cmd.arm     = take && (item.opcode == OP_ARM) && id_ok;
    cmd.disarm  = take && (item.opcode == OP_DISARM) && id_ok;
    cmd.rd_en   = (state == WALK);
    cmd.rd_last = (state == WALK) && (idx == LAST_IDX);
    cmd.finish  = (state == FINISH);
  end

  assign rd_addr = idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      idx   <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          idx <= '0;
          if (take && (item.opcode == OP_TICK)) begin
            state <= WALK;
          end
        end
        WALK: begin
          idx <= idx + 1'b1;
          if (idx == LAST_IDX) begin
            state <= DRAIN;
          end
        end
        DRAIN: begin
          // last entry is being processed this cycle
          if (status.walk_done) begin
            state <= FINISH;
          end
        end
        FINISH: begin
          state <= IDLE;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

FILE: design/osat_datapath.sv
module osat_datapath #(
  parameter int ALARM_COUNT = 16,
  parameter int IDX_W = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  osat_pkg::item_t     item,
  input  osat_pkg::cmd_t      cmd,
  input  logic [IDX_W-1:0]    rd_addr,
  output osat_pkg::status_t   status,
  output osat_pkg::result_t   result,
  output logic                result_vld
);
  import osat_pkg::*;

  // entry layout: count in the upper half, limit in the lower half
  logic [2*CNT_W-1:0] mem [ALARM_COUNT];
  logic [2*CNT_W-1:0] rd_q;

  logic [ALARM_COUNT-1:0] armed;
  logic [ALARM_COUNT-1:0] notify_en;

  logic             pvld;
  logic             plast;
  logic [IDX_W-1:0] pidx;
  logic             have_pend;
  logic [ID_W-1:0]  pend_id;

  logic [CNT_W-1:0]   cnt_inc;
  logic [CNT_W-1:0]   limit;
  logic               hit;
  logic               fire;
  logic               we;
  logic [IDX_W-1:0]   wa;
  logic [2*CNT_W-1:0] wd;
  logic [IDX_W-1:0]   id_idx;

  assign id_idx  = IDX_W'(item.alarm_id);
  assign limit   = rd_q[CNT_W-1:0];
  assign cnt_inc = rd_q[2*CNT_W-1:CNT_W] + 1'b1;
  assign hit     = pvld && armed[pidx];
  assign fire    = hit && (cnt_inc >= limit);

  assign status.walk_done = pvld && plast;

  always_comb begin
    we = 1'b0;
    wa = pidx;
    wd = {cnt_inc, limit};
    if (cmd.arm) begin
      we = 1'b1;
      wa = id_idx;
      wd = {{CNT_W{1'b0}}, item.timeout};
    end else if (hit && !fire) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_q <= mem[rd_addr];
    end
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed      <= '0;
      notify_en  <= '0;
      pvld       <= 1'b0;
      plast      <= 1'b0;
      have_pend  <= 1'b0;
      result_vld <= 1'b0;
    end else begin
      pvld       <= cmd.rd_en;
      plast      <= cmd.rd_last;
      // a held hit goes out when the next one arrives or at the end of the walk
      result_vld <= (fire && notify_en[pidx] && have_pend) || cmd.finish;

      if (cmd.arm) begin
        armed[id_idx]     <= 1'b1;
        notify_en[id_idx] <= item.notify;
      end
      if (cmd.disarm) begin
        armed[id_idx] <= 1'b0;
      end
      if (fire) begin
        armed[pidx] <= 1'b0;
        if (notify_en[pidx]) begin
          // hold the newest hit back: only the end of the walk knows which is last
          have_pend <= 1'b1;
        end
      end
      if (cmd.finish) begin
        have_pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pidx <= rd_addr;
    if (fire && notify_en[pidx]) begin
      pend_id            <= ID_W'(pidx);
      result.fired_id    <= pend_id;
      result.fired_valid <= 1'b1;
      result.last        <= 1'b0;
    end
    if (cmd.finish) begin
      result.fired_id    <= have_pend ? pend_id : '0;
      result.fired_valid <= have_pend;
      result.last        <= 1'b1;
    end
  end

endmodule

FILE: design/one_shot_alarm_table_unit.sv
// Table of one-shot alarms.
// Input: an item is taken at a clock edge with start high and busy low.
//   opcode arm loads timeout and notify into alarm_id and zeroes its count,
//   disarm stops it, tick advances every armed alarm; ids past the table
//   and the unused opcode are dropped.
// Output: result_vld marks each result for a single cycle; the receiver
//   cannot stall. Only ticks give results: one per fired alarm with
//   notify set, ascending id, last on the final one, or a single result
//   with fired_valid 0 and last 1 when nothing reports.
// Timing: arm, disarm and unused opcodes leave busy low.
//   A tick holds busy while it walks the count/limit table, a memory with
//   one read and one write port, walked one entry a cycle with a
//   registered read, then drains the last entry and emits the final
//   result. The final result appears in the cycle busy drops; earlier ones
//   while busy is high.
// Reset: all alarms disarmed, no result pending. The table memory needs
//   no clearing; an entry's contents count only once its armed bit is set.
module one_shot_alarm_table_unit #(
  parameter int ALARM_COUNT = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  osat_pkg::item_t   item,
  output logic              busy,
  output osat_pkg::result_t result,
  output logic              result_vld
);
  import osat_pkg::*;

  localparam int IDX_W = (ALARM_COUNT > 1) ? $clog2(ALARM_COUNT) : 1;

  cmd_t             cmd;
  status_t          status;
  logic [IDX_W-1:0] rd_addr;

  osat_ctrl #(
    .ALARM_COUNT(ALARM_COUNT),
    .IDX_W(IDX_W)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .start(start),
    .item(item),
    .status(status),
    .busy(busy),
    .cmd(cmd),
    .rd_addr(rd_addr)
  );

  osat_datapath #(
    .ALARM_COUNT(ALARM_COUNT),
    .IDX_W(IDX_W)
  ) u_datapath (
    .clk(clk),
    .rst(rst),
    .item(item),
    .cmd(cmd),
    .rd_addr(rd_addr),
    .status(status),
    .result(result),
    .result_vld(result_vld)
  );

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    result_vld && !result.fired_valid |-> result.last)
    else $error("empty tick result without last");

  a_tick_ends_with_last: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> result_vld && result.last)
    else $error("tick finished without a final result");

  a_mid_result_while_busy: assert property (@(posedge clk) disable iff (rst)
    result_vld && !result.last |-> busy)
    else $error("non-final result outside a tick");

  a_short_ops_one_cycle: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (item.opcode != OP_TICK) |=> !busy && !result_vld)
    else $error("arm or disarm held the block or gave a result");

endmodule
